/* rtl/xor_checksum_frame_decoder_defines.svh */
// ----------------------------------------------------------------------------
// xor_checksum_frame_decoder_defines.svh
// Assertion macros for the frame decoder; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKSUM_FRAME_DECODER_DEFINES_SVH
`define XOR_CHECKSUM_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define XCFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("xcfd assertion failed");
// checked property, also checked during reset
`define XCFD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("xcfd assertion failed");
`else
`define XCFD_ASSERT(lbl, clk, rst, prop)
`define XCFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/xcfd_pkg.sv */
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared constants, codes and types of the xor checksum frame decoder.
// ----------------------------------------------------------------------------
package xcfd_pkg;

   // payload store size and derived widths
   localparam int PAYLOAD_DEPTH = 128;
   localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
   localparam int IDX_W         = 7;
   localparam int LEN_OUT_W     = 7;

   localparam logic [7:0] START_BYTE = 8'hFE;

   // parser phases
   typedef enum logic [2:0] {
      PH_WAIT,
      PH_FN_HI,
      PH_FN_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_SUM
   } phase_type;

   // result event codes
   typedef enum logic [2:0] {
      EV_NONE,
      EV_OK,
      EV_BAD_SUM,
      EV_TOO_LONG,
      EV_READ
   } event_type;

   // store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_port_type;

   // parser result for one beat
   typedef struct packed {
      event_type              ev;
      logic [15:0]            func;
      logic [LEN_OUT_W-1:0]   len;
   } result_type;

endpackage

/* rtl/xcfd_if.sv */
// ----------------------------------------------------------------------------
// xcfd_if
// Valid/ready channels of the frame decoder: request and response beats.
// ----------------------------------------------------------------------------
interface xcfd_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   logic [6:0] read_index;

   modport source (output valid, mode, rx_byte, read_index, input ready);
   modport sink (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface xcfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [15:0] frame_function;
   logic [6:0]  frame_length;
   logic [7:0]  read_data;

   modport source (output valid, event_res, frame_function, frame_length, read_data,
                   input ready);
   modport sink (input valid, event_res, frame_function, frame_length, read_data,
                 output ready);
endinterface

/* rtl/xcfd_parser.sv */
// ----------------------------------------------------------------------------
// xcfd_parser
// Frame parse state machine with running xor checksum; drives store writes.
// ----------------------------------------------------------------------------
`include "xor_checksum_frame_decoder_defines.svh"

module xcfd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  mode,
   input  logic [7:0]            rx_byte,
   output xcfd_pkg::wr_port_type wr_port,
   output xcfd_pkg::result_type  result
);
   import xcfd_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [15:0]       function_ff, function_in;
   logic [7:0]        len_hi_ff, len_hi_in;
   logic [ADDR_W-1:0] length_ff, length_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [7:0]        sum_ff, sum_in;
   logic              parse;
   logic [15:0]       full_len;
   logic              too_long;
   logic [ADDR_W:0]   pos_inc;
   logic [ADDR_W+LEN_OUT_W-1:0] len_wide;

   assign parse    = step & ~mode;
   assign full_len = {len_hi_ff, rx_byte};
   assign too_long = (full_len >= 16'(PAYLOAD_DEPTH));
   assign pos_inc  = {1'b0, pos_ff} + {{ADDR_W{1'b0}}, 1'b1};
   assign len_wide = {{LEN_OUT_W{1'b0}}, length_ff};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (parse) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (rx_byte == START_BYTE) phase_in = PH_FN_HI;
            end
            PH_FN_HI:  phase_in = PH_FN_LO;
            PH_FN_LO:  phase_in = PH_LEN_HI;
            PH_LEN_HI: phase_in = PH_LEN_LO;
            PH_LEN_LO: begin
               priority if (full_len == 16'd0) phase_in = PH_SUM;
               else if (too_long)              phase_in = PH_WAIT;
               else                            phase_in = PH_DATA;
            end
            PH_DATA: begin
               if (pos_inc >= {1'b0, length_ff}) phase_in = PH_SUM;
            end
            PH_SUM:  phase_in = PH_WAIT;
            default: phase_in = PH_WAIT;
         endcase
      end
   end

   // datapath updates and result of the current beat
   always_comb begin
      function_in  = function_ff;
      len_hi_in    = len_hi_ff;
      length_in    = length_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff ^ rx_byte;
      wr_port.en   = 1'b0;
      wr_port.addr = pos_ff;
      wr_port.data = rx_byte;
      result.ev    = EV_NONE;
      result.func  = 16'd0;
      result.len   = '0;
      if (mode) begin
         result.ev = EV_READ;
      end else begin
         unique case (phase_ff)
            PH_WAIT:   sum_in = START_BYTE;
            PH_FN_HI:  function_in = {rx_byte, 8'h00};
            PH_FN_LO:  function_in = {function_ff[15:8], rx_byte};
            PH_LEN_HI: len_hi_in = rx_byte;
            PH_LEN_LO: begin
               length_in = full_len[ADDR_W-1:0];
               pos_in    = '0;
               if (too_long) begin
                  result.ev   = EV_TOO_LONG;
                  result.func = function_ff;
               end
            end
            PH_DATA: begin
               wr_port.en = step;
               pos_in     = pos_inc[ADDR_W-1:0];
            end
            PH_SUM: begin
               result.ev   = (sum_ff == rx_byte) ? EV_OK : EV_BAD_SUM;
               result.func = function_ff;
               result.len  = len_wide[LEN_OUT_W-1:0];
            end
            default: sum_in = sum_ff;
         endcase
      end
   end

   // parse registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
      end else begin
         phase_ff <= phase_in;
      end
      if (parse) begin
         function_ff <= function_in;
         len_hi_ff   <= len_hi_in;
         length_ff   <= length_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
      end
   end

   // a frame with payload never enters the data phase with zero length
   `XCFD_ASSERT(a_data_len_nonzero, clock, reset, (phase_ff == PH_DATA) |-> (length_ff != '0))
   // the write position stays below the frame length
   `XCFD_ASSERT(a_data_pos_in_frame, clock, reset, (phase_ff == PH_DATA) |-> (pos_ff < length_ff))
   // a store read leaves the parse phase alone
   `XCFD_ASSERT(a_read_keeps_phase, clock, reset, (step && mode) |=> $stable(phase_ff))

endmodule

/* rtl/xcfd_store.sv */
// ----------------------------------------------------------------------------
// xcfd_store
// Payload byte store with per-entry valid bits and a registered read port.
// ----------------------------------------------------------------------------
module xcfd_store (
   input  logic                  clock,
   input  logic                  reset,
   input  xcfd_pkg::wr_port_type wr_port,
   input  logic                  rd_en,
   input  logic                  rd_sel,
   input  logic [6:0]            read_index,
   output logic [7:0]            read_data
);
   import xcfd_pkg::*;

   logic [7:0]               mem [PAYLOAD_DEPTH];
   logic [PAYLOAD_DEPTH-1:0] valid_ff;
   logic [7:0]               raw_ff;
   logic                     hit_ff, hit_in;
   logic [ADDR_W+IDX_W-1:0]  idx_wide;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     in_range;

   // read address and range check
   assign idx_wide = {{ADDR_W{1'b0}}, read_index};
   assign rd_addr  = idx_wide[ADDR_W-1:0];
   assign in_range = (idx_wide < (ADDR_W+IDX_W)'(PAYLOAD_DEPTH));
   assign hit_in   = rd_sel & in_range & valid_ff[rd_addr];

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_port.en) mem[wr_port.addr] <= wr_port.data;
      if (rd_en) raw_ff <= mem[rd_addr];
   end

   // valid bits and read hit flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_port.en) valid_ff[wr_port.addr] <= 1'b1;
         if (rd_en) hit_ff <= hit_in;
      end
   end

   // unwritten entries and non-read beats read as zero
   assign read_data = hit_ff ? raw_ff : 8'h00;

endmodule

/* rtl/xor_checksum_frame_decoder.sv */
// ----------------------------------------------------------------------------
// xor_checksum_frame_decoder
// Serial frame decoder with xor checksum and a readable payload store.
// ----------------------------------------------------------------------------
// Takes one beat per clock while responses are accepted and returns exactly one
// response beat per request, in order. A beat with mode 0 feeds the frame
// parser (start byte 0xFE, function code, length, payload, checksum); mode 1
// reads one byte of the 128-entry payload store. A beat passes through the
// request register, then the response register, with the parser state and the
// store's registered read port updated at the same edge as the response
// register. The request side stays ready while a response waits, as long as
// the request register is free, so throughput is one beat per cycle without
// back-pressure. Store entries carry valid bits cleared by reset, so the block
// is usable right after reset; entries never written read as zero.
// ----------------------------------------------------------------------------
`include "xor_checksum_frame_decoder_defines.svh"

module xor_checksum_frame_decoder (
   input logic        clock,
   input logic        reset,
   xcfd_req_if.sink   req_bus,
   xcfd_rsp_if.source rsp_bus
);
   import xcfd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [7:0]  in_byte_ff;
   logic [6:0]  in_index_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   event_type   event_ff;
   logic [15:0] function_ff;
   logic [6:0]  length_ff;
   logic        req_accept;
   logic        advance;
   wr_port_type wr_port;
   result_type  result;

   // handshake
   assign advance       = in_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_accept    = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)   in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance)            rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_mode_ff  <= req_bus.mode;
         in_byte_ff  <= req_bus.rx_byte;
         in_index_ff <= req_bus.read_index;
      end
   end

   // parser
   xcfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .mode    (in_mode_ff),
      .rx_byte (in_byte_ff),
      .wr_port (wr_port),
      .result  (result)
   );

   // payload store
   xcfd_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_port    (wr_port),
      .rd_en      (advance),
      .rd_sel     (in_mode_ff),
      .read_index (in_index_ff),
      .read_data  (rsp_bus.read_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         event_ff    <= result.ev;
         function_ff <= result.func;
         length_ff   <= result.len;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.event_res      = event_ff;
   assign rsp_bus.frame_function = function_ff;
   assign rsp_bus.frame_length   = length_ff;

   // request side only stalls when both registers hold a beat and output is blocked
   `XCFD_ASSERT(a_stall_only_when_full, clock, reset, !req_bus.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_bus.ready))
   // store data shows only on read replies
   `XCFD_ASSERT(a_read_data_only_on_read, clock, reset, (rsp_valid_ff && (event_ff != EV_READ)) |-> (rsp_bus.read_data == 8'h00))
   // an accepted request is held in the request register
   `XCFD_ASSERT(a_accept_fills_reg, clock, reset, req_accept |=> in_valid_ff)

endmodule
